[hw/rtl/spq_pkg.sv]
package spq_pkg;

  localparam int QUEUE_COUNT_DEF = 4;
  localparam int QUEUE_DEPTH_DEF = 64;

  localparam int CAP_W = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [1:0] REQ_INSERT  = 2'd0;
  localparam logic [1:0] REQ_POP     = 2'd1;
  localparam logic [1:0] REQ_SEARCH  = 2'd2;
  localparam logic [1:0] REQ_EXTRACT = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_ZERO      = 3'd4;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  queue_sel;
    logic [31:0] entry_key;
    logic [31:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_key;
    logic [31:0] out_value;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [31:0] value;
  } entry_t;

endpackage

[hw/rtl/sorted_priority_queue_lazy_delete_core.sv]
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_ready   | in_data (in_item_t)
// out     | output    | out_valid/out_ready | out_data (out_item_t)
// cfg     | input     | cfg_we              | cfg_wdata (queue capacity)
//
// one transaction at a time; the single-port-per-direction entry memory sets the pace
// insert: backward walk over the entries with a larger key, one entry moved per cycle
// pop, search, extract: forward walk over the entries scanned, one memory read per cycle
// a finished result sits in the output register while the next transaction is taken
// rst_n (synchronous) clears occupancy, head pointers and control; entries need no clearing
module sorted_priority_queue_lazy_delete_core
  import spq_pkg::*;
#(
  parameter int QUEUE_COUNT = QUEUE_COUNT_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  localparam int Q_W    = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W = $clog2(QUEUE_COUNT * QUEUE_DEPTH);
  localparam int SLOTS  = QUEUE_COUNT * QUEUE_DEPTH;

  // controller states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1; // backward walk, shifting larger keys up
  localparam logic [2:0] S_FIN  = 3'd2; // write the new entry
  localparam logic [2:0] S_SCAN = 3'd3; // forward walk for pop, search, extract
  localparam logic [2:0] S_OUT  = 3'd4; // hand the result to the output register

  // entry memory: one write port, one registered read port
  entry_t              mem [SLOTS];
  entry_t              rdata_r;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  entry_t              wr_data;

  logic [2:0]          state_r, state_nxt;
  in_item_t            req_r, req_nxt;
  logic [Q_W-1:0]      qi_r, qi_nxt;
  logic [OCC_W-1:0]    occ_r [QUEUE_COUNT];
  logic [OCC_W-1:0]    occ_nxt [QUEUE_COUNT];
  logic [IDX_W-1:0]    head_r [QUEUE_COUNT];
  logic [IDX_W-1:0]    head_nxt [QUEUE_COUNT];
  logic [CAP_W-1:0]    cap_r;
  logic [IDX_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                rd_more_r, rd_more_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic [IDX_W-1:0]    pend_i_r, pend_i_nxt;
  logic [IDX_W-1:0]    pos_r, pos_nxt;
  out_item_t           res_r, res_nxt;
  logic                out_valid_r;
  out_item_t           out_data_r;

  logic [Q_W-1:0]      in_q;
  logic [OCC_W-1:0]    in_occ;
  logic [OCC_W-1:0]    cur_occ;
  logic [IDX_W-1:0]    cur_head;
  logic                last;
  logic                accept;

  // offset inside a queue, wrapped round the circular buffer
  function automatic logic [IDX_W-1:0] wrap(input logic [IDX_W:0] s);
    logic [IDX_W:0] t;
    t = s;
    if (s >= (IDX_W+1)'(QUEUE_DEPTH)) begin
      t = s - (IDX_W+1)'(QUEUE_DEPTH);
    end
    return t[IDX_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] phys(input logic [Q_W-1:0] q,
                                             input logic [IDX_W-1:0] h,
                                             input logic [IDX_W:0] j);
    logic [IDX_W-1:0] off;
    off = wrap({1'b0, h} + j);
    return ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(off);
  endfunction

  assign in_q     = Q_W'(in_data.queue_sel);
  assign in_occ   = occ_r[in_q];
  assign cur_occ  = occ_r[qi_r];
  assign cur_head = head_r[qi_r];
  assign last     = (OCC_W'(pend_i_r) + OCC_W'(1)) == cur_occ;
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // reads run one step ahead of the compare on the returned entry
  assign rd_en   = rd_more_r && ((state_r == S_INS) || (state_r == S_SCAN));
  assign rd_addr = phys(qi_r, cur_head, {1'b0, rd_idx_r});

  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    qi_nxt      = qi_r;
    occ_nxt     = occ_r;
    head_nxt    = head_r;
    rd_idx_nxt  = rd_idx_r;
    rd_more_nxt = rd_more_r;
    pend_v_nxt  = 1'b0;
    pend_i_nxt  = pend_i_r;
    pos_nxt     = pos_r;
    res_nxt     = res_r;
    wr_en       = 1'b0;
    wr_addr     = phys(qi_r, cur_head, {1'b0, pos_r});
    wr_data     = '{valid: 1'b1, key: req_r.entry_key, value: req_r.entry_value};

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt     = in_data;
          qi_nxt      = in_q;
          res_nxt     = '{status: ST_OK, out_key: ALL_ONES, out_value: ALL_ONES};
          rd_more_nxt = 1'b1;
          if (in_data.req_type == REQ_INSERT && in_data.entry_key == '0
              && in_data.entry_value == '0) begin
            res_nxt.status = ST_ZERO;
            state_nxt      = S_OUT;
          end else if (32'(in_data.queue_sel) >= QUEUE_COUNT) begin
            // queue that does not exist
            if (in_data.req_type == REQ_INSERT) begin
              res_nxt.status = ST_FULL;
            end else if (in_data.req_type == REQ_POP) begin
              res_nxt.status = ST_EMPTY;
            end else begin
              res_nxt.status = ST_NOT_FOUND;
            end
            state_nxt = S_OUT;
          end else if (in_data.req_type == REQ_INSERT) begin
            if (32'(in_occ) >= 32'(cap_r) || 32'(in_occ) >= QUEUE_DEPTH) begin
              res_nxt.status = ST_FULL;
              state_nxt      = S_OUT;
            end else if (in_occ == '0) begin
              pos_nxt   = '0;
              state_nxt = S_FIN;
            end else begin
              rd_idx_nxt = IDX_W'(in_occ - OCC_W'(1));
              state_nxt  = S_INS;
            end
          end else begin
            if (in_occ == '0) begin
              res_nxt.status = (in_data.req_type == REQ_POP) ? ST_EMPTY : ST_NOT_FOUND;
              state_nxt      = S_OUT;
            end else begin
              rd_idx_nxt = '0;
              state_nxt  = S_SCAN;
            end
          end
        end
      end

      S_INS: begin
        pend_v_nxt  = rd_more_r;
        pend_i_nxt  = rd_idx_r;
        rd_more_nxt = rd_more_r && (rd_idx_r != '0);
        rd_idx_nxt  = rd_idx_r - IDX_W'(1);
        if (pend_v_r) begin
          if (rdata_r.key > req_r.entry_key) begin
            wr_en   = 1'b1;
            wr_addr = phys(qi_r, cur_head, {1'b0, pend_i_r} + (IDX_W+1)'(1));
            wr_data = rdata_r;
            if (pend_i_r == '0) begin
              pos_nxt   = '0;
              state_nxt = S_FIN;
            end
          end else begin
            pos_nxt   = pend_i_r + IDX_W'(1);
            state_nxt = S_FIN;
          end
        end
      end

      S_FIN: begin
        wr_en           = 1'b1;
        occ_nxt[qi_r]   = cur_occ + OCC_W'(1);
        state_nxt       = S_OUT;
      end

      S_SCAN: begin
        pend_v_nxt  = rd_more_r;
        pend_i_nxt  = rd_idx_r;
        rd_more_nxt = rd_more_r && ((OCC_W'(rd_idx_r) + OCC_W'(1)) < cur_occ);
        rd_idx_nxt  = rd_idx_r + IDX_W'(1);
        if (pend_v_r) begin
          if (req_r.req_type == REQ_POP) begin
            if (rdata_r.valid) begin
              // drop everything up to and including the entry returned
              res_nxt        = '{status: ST_OK, out_key: rdata_r.key,
                                 out_value: rdata_r.value};
              head_nxt[qi_r] = wrap({1'b0, cur_head} + {1'b0, pend_i_r}
                                    + (IDX_W+1)'(1));
              occ_nxt[qi_r]  = cur_occ - OCC_W'(pend_i_r) - OCC_W'(1);
              state_nxt      = S_OUT;
            end else if (last) begin
              res_nxt.status = ST_EMPTY;
              occ_nxt[qi_r]  = '0;
              state_nxt      = S_OUT;
            end
          end else begin
            if (rdata_r.key > req_r.entry_key) begin
              res_nxt.status = ST_NOT_FOUND;
              state_nxt      = S_OUT;
            end else if (rdata_r.key == req_r.entry_key && rdata_r.valid) begin
              res_nxt = '{status: ST_OK, out_key: rdata_r.key, out_value: rdata_r.value};
              if (req_r.req_type == REQ_EXTRACT) begin
                // lazy delete: the slot stays until a pop passes it
                wr_en         = 1'b1;
                wr_addr       = phys(qi_r, cur_head, {1'b0, pend_i_r});
                wr_data       = rdata_r;
                wr_data.valid = 1'b0;
              end
              state_nxt = S_OUT;
            end else if (last) begin
              res_nxt.status = ST_NOT_FOUND;
              state_nxt      = S_OUT;
            end
          end
        end
      end

      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      qi_r        <= '0;
      cap_r       <= CAP_RESET;
      rd_more_r   <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        occ_r[i]  <= '0;
        head_r[i] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      qi_r      <= qi_nxt;
      rd_more_r <= rd_more_nxt;
      pend_v_r  <= pend_v_nxt;
      occ_r     <= occ_nxt;
      head_r    <= head_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    rd_idx_r <= rd_idx_nxt;
    pend_i_r <= pend_i_nxt;
    pos_r    <= pos_nxt;
    res_r    <= res_nxt;
    if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cur_occ) <= QUEUE_DEPTH)
    else $error("occupancy beyond queue depth");

  a_write_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_INS || state_r == S_FIN || state_r == S_SCAN))
    else $error("memory write outside a walk");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write hit the same slot");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("transaction accepted but controller stayed idle");

endmodule

[tb/tb.sv]
module tb;
  import spq_pkg::*;

  localparam int NQ = QUEUE_COUNT_DEF;
  localparam int DEPTH = QUEUE_DEPTH_DEF;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;

  // shadow of the queues: per queue a sorted list of entries
  entry_t shadow_q [NQ][$];
  logic [CAP_W-1:0] shadow_cap;
  out_item_t pending_results [$];
  int error_count = 0;
  int idle_cycles = 0;
  logic [3:0] stall_pattern;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sorted_priority_queue_lazy_delete_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // predicts the result of one request and updates the shadow queues
  function automatic out_item_t serve_request(in_item_t req);
    out_item_t res;
    entry_t e;
    int pos;
    int cap;
    res = '{status: ST_OK, out_key: ALL_ONES, out_value: ALL_ONES};
    if (req.req_type == REQ_INSERT && req.entry_key == 0 && req.entry_value == 0) begin
      res.status = ST_ZERO;
      return res;
    end
    case (req.req_type)
      REQ_INSERT: begin
        cap = (int'(shadow_cap) > DEPTH) ? DEPTH : int'(shadow_cap);
        if (shadow_q[req.queue_sel].size() >= cap) begin
          res.status = ST_FULL;
        end else begin
          pos = shadow_q[req.queue_sel].size();
          while (pos > 0 && shadow_q[req.queue_sel][pos-1].key > req.entry_key) pos--;
          e = '{valid: 1'b1, key: req.entry_key, value: req.entry_value};
          shadow_q[req.queue_sel].insert(pos, e);
        end
      end
      REQ_POP: begin
        res.status = ST_EMPTY;
        while (shadow_q[req.queue_sel].size() > 0) begin
          e = shadow_q[req.queue_sel].pop_front();
          if (e.valid) begin
            res = '{status: ST_OK, out_key: e.key, out_value: e.value};
            break;
          end
        end
      end
      default: begin
        res.status = ST_NOT_FOUND;
        for (int i = 0; i < shadow_q[req.queue_sel].size(); i++) begin
          e = shadow_q[req.queue_sel][i];
          if (e.key > req.entry_key) break;
          if (e.key == req.entry_key && e.valid) begin
            res = '{status: ST_OK, out_key: e.key, out_value: e.value};
            if (req.req_type == REQ_EXTRACT) shadow_q[req.queue_sel][i].valid = 1'b0;
            break;
          end
        end
      end
    endcase
    return res;
  endfunction

  // result checking
  always @(posedge clk) begin
    out_item_t exp_item;
    if (out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected transaction: status %0d key %h value %h",
               out_data.status, out_data.out_key, out_data.out_value);
        error_count++;
      end else begin
        exp_item = pending_results.pop_front();
        if (out_data.status !== exp_item.status) begin
          $error("status: expected %0d, actual %0d", exp_item.status, out_data.status);
          error_count++;
        end
        if (out_data.out_key !== exp_item.out_key) begin
          $error("out_key: expected %h, actual %h", exp_item.out_key, out_data.out_key);
          error_count++;
        end
        if (out_data.out_value !== exp_item.out_value) begin
          $error("out_value: expected %h, actual %h", exp_item.out_value, out_data.out_value);
          error_count++;
        end
      end
    end
  end

  // watchdog: counts cycles without any accepted transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: stall pattern changes now and then, sometimes never stalls
  initial begin
    stall_pattern = 4'b0000;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 63) == 0) begin
        stall_pattern = ($urandom_range(0, 2) == 0) ? 4'b0000 : 4'($urandom);
      end
      out_ready <= !stall_pattern[$urandom_range(0, 3)];
    end
  end

  // sends one transaction; valid stays high across back-to-back items
  task automatic send_request(input logic [1:0] kind, input logic [1:0] qsel,
                              input logic [31:0] key, input logic [31:0] value);
    in_item_t req;
    req = '{req_type: kind, queue_sel: qsel, entry_key: key, entry_value: value};
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(serve_request(req));
    @(negedge clk);
    // random gap between bursts
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    // all results are in; idle a while longer before going on
    repeat (3 * DEPTH + 10) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow_cap = cap;
  endtask

  // random key, from a narrow range unless wide is set, so that duplicates and matches happen
  function automatic logic [31:0] pick_key(input bit wide);
    if (wide) return $urandom;
    return $urandom_range(0, 15);
  endfunction

  task automatic test_directed();
    send_request(REQ_POP, 2'd0, 32'd0, 32'd0);
    send_request(REQ_INSERT, 2'd0, 32'd0, 32'd0);
    send_request(REQ_INSERT, 2'd0, 32'd0, 32'd1);
    send_request(REQ_INSERT, 2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_INSERT, 2'd0, 32'd7, 32'hA5A5_0001);
    send_request(REQ_INSERT, 2'd0, 32'd7, 32'h5A5A_0002);
    send_request(REQ_INSERT, 2'd0, 32'd3, 32'h1234_5678);
    send_request(REQ_SEARCH, 2'd0, 32'd7, 32'd0);
    send_request(REQ_EXTRACT, 2'd0, 32'd7, 32'd0);
    send_request(REQ_SEARCH, 2'd0, 32'd7, 32'd0);
    send_request(REQ_EXTRACT, 2'd0, 32'd8, 32'd0);
    send_request(REQ_SEARCH, 2'd3, 32'd7, 32'd0);
    send_request(REQ_EXTRACT, 2'd0, 32'hFFFF_FFFF, 32'd0);
    send_request(REQ_INSERT, 2'd3, 32'h8000_0000, 32'h0000_FFFF);
    repeat (5) send_request(REQ_POP, 2'd0, 32'd0, 32'd0);
    // only invalid entries left
    send_request(REQ_INSERT, 2'd1, 32'd9, 32'd9);
    send_request(REQ_EXTRACT, 2'd1, 32'd9, 32'd0);
    send_request(REQ_POP, 2'd1, 32'd0, 32'd0);
    send_request(REQ_POP, 2'd3, 32'd0, 32'd0);
  endtask

  task automatic test_capacity_limits();
    write_capacity(7'd0);
    send_request(REQ_INSERT, 2'd2, 32'd1, 32'd1);
    write_capacity(7'd1);
    send_request(REQ_INSERT, 2'd2, 32'd1, 32'd1);
    send_request(REQ_INSERT, 2'd2, 32'd2, 32'd2);
    send_request(REQ_POP, 2'd2, 32'd0, 32'd0);
    write_capacity(7'd127);
    // fill one queue past its depth
    for (int i = 0; i < DEPTH + 2; i++)
      send_request(REQ_INSERT, 2'd2, pick_key(1'b0), $urandom);
    // lowering below occupancy drops nothing
    write_capacity(7'd3);
    send_request(REQ_INSERT, 2'd2, 32'd5, 32'd5);
    repeat (DEPTH + 1) send_request(REQ_POP, 2'd2, 32'd0, 32'd0);
  endtask

  task automatic test_random(input int count);
    logic [1:0] kind;
    logic [1:0] qsel;
    int roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      kind = (roll < 40) ? REQ_INSERT : (roll < 65) ? REQ_POP :
             (roll < 82) ? REQ_SEARCH : REQ_EXTRACT;
      qsel = 2'($urandom_range(0, NQ - 1));
      send_request(kind, qsel, pick_key($urandom_range(0, 4) == 0), $urandom);
    end
  endtask

  initial begin
    shadow_cap = CAP_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_capacity_limits();
    write_capacity(7'd64);
    test_random(200);
    write_capacity(7'd5);
    test_random(200);
    write_capacity(7'd20);
    test_random(200);
    drain_results();
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
